// ===== hw/rtl/rtcm3_frame_type_byte_counter_top_macros.svh =====
// assertion macros for the rtcm3 frame type byte counter
`ifndef RTCM3_FRAME_TYPE_BYTE_COUNTER_TOP_MACROS_SVH
`define RTCM3_FRAME_TYPE_BYTE_COUNTER_TOP_MACROS_SVH

// same-cycle implication
`define RTCM_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define RTCM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/rtcm_pkg.sv =====
// shared types and constants for the rtcm3 frame type byte counter
package rtcm_pkg;

  localparam int TABLE_DEPTH_DEF = 24;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = 2;

  localparam logic [7:0]  PREAMBLE       = 8'hD3;
  localparam logic [9:0]  MIN_PAYLOAD    = 10'd2;
  localparam logic [10:0] FRAME_OVERHEAD = 11'd6;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic {
    OP_CREDIT = 1'b0,
    OP_READ   = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [11:0] type_code;
    logic [10:0] amount;
    logic [4:0]  read_index;
  } queue_item_t;

  typedef struct packed {
    logic [11:0] type_code;
    logic [31:0] count;
  } entry_t;

endpackage

// ===== hw/rtl/rtcm_front.sv =====
// frame parser: accepts transactions and queues credit and read operations
module rtcm_front
  import rtcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  data_byte,
  input  logic [4:0]  read_index,
  input  logic        q_full,
  output logic        push,
  output queue_item_t push_item
);

  typedef enum logic [5:0] {
    P_HUNT  = 6'b000001,
    P_LEN1  = 6'b000010,
    P_LEN2  = 6'b000100,
    P_TYPE1 = 6'b001000,
    P_TYPE2 = 6'b010000,
    P_REST  = 6'b100000
  } parse_state_t;

  parse_state_t parse_state, parse_state_next;
  logic [1:0]   length_high_bits, length_high_bits_next;
  logic [7:0]   type_high_byte, type_high_byte_next;
  logic [11:0]  current_type, current_type_next;
  logic [10:0]  frame_length, frame_length_next;
  logic [10:0]  bytes_seen, bytes_seen_next;
  logic [10:0]  seen_inc;
  logic [9:0]   body_len;
  logic         accept;
  logic         feed;
  logic         frame_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign feed     = accept && (command == CMD_FEED);
  assign seen_inc = bytes_seen + 11'd1;
  assign body_len = {length_high_bits, data_byte};

  always_comb begin
    parse_state_next      = parse_state;
    length_high_bits_next = length_high_bits;
    type_high_byte_next   = type_high_byte;
    current_type_next     = current_type;
    frame_length_next     = frame_length;
    bytes_seen_next       = bytes_seen;
    frame_end             = 1'b0;
    if (feed) begin
      case (parse_state)
        P_LEN1: begin
          length_high_bits_next = data_byte[1:0];
          bytes_seen_next       = seen_inc;
          parse_state_next      = P_LEN2;
        end
        P_LEN2: begin
          bytes_seen_next = seen_inc;
          if (body_len < MIN_PAYLOAD) begin
            parse_state_next = P_HUNT;
          end else begin
            frame_length_next = {1'b0, body_len} + FRAME_OVERHEAD;
            parse_state_next  = P_TYPE1;
          end
        end
        P_TYPE1: begin
          type_high_byte_next = data_byte;
          bytes_seen_next     = seen_inc;
          parse_state_next    = P_TYPE2;
        end
        P_TYPE2: begin
          current_type_next = {type_high_byte, data_byte[7:4]};
          bytes_seen_next   = seen_inc;
          parse_state_next  = P_REST;
        end
        P_REST: begin
          bytes_seen_next = seen_inc;
          if (seen_inc >= frame_length) begin
            frame_end        = 1'b1;
            parse_state_next = P_HUNT;
          end
        end
        default: begin
          if (data_byte == PREAMBLE) begin
            bytes_seen_next  = 11'd1;
            parse_state_next = P_LEN1;
          end else begin
            parse_state_next = P_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state      <= P_HUNT;
      length_high_bits <= '0;
      type_high_byte   <= '0;
      current_type     <= '0;
      frame_length     <= '0;
      bytes_seen       <= '0;
    end else begin
      parse_state      <= parse_state_next;
      length_high_bits <= length_high_bits_next;
      type_high_byte   <= type_high_byte_next;
      current_type     <= current_type_next;
      frame_length     <= frame_length_next;
      bytes_seen       <= bytes_seen_next;
    end
  end

  always_comb begin
    push                 = frame_end || (accept && (command == CMD_READ));
    push_item.kind       = (command == CMD_READ) ? OP_READ : OP_CREDIT;
    push_item.type_code  = current_type;
    push_item.amount     = frame_length;
    push_item.read_index = read_index;
  end

endmodule

// ===== hw/rtl/rtcm_queue.sv =====
// short fifo between the parser and the table engine
module rtcm_queue
  import rtcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_item_t push_item,
  output logic        full,
  output logic        pop_valid,
  output queue_item_t pop_item,
  input  logic        pop
);

  queue_item_t       items [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = items[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      items[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/rtcm_back.sv =====
// table engine: type search, count update, entry reads and result register
module rtcm_back
  import rtcm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  queue_item_t                          q_item,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 entry_valid,
  output logic [11:0]                          entry_type,
  output logic [31:0]                          entry_bytes,
  output logic [4:0]                           table_fill,
  output logic [$clog2(TABLE_DEPTH + 1)-1:0]   fill
);

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W  = (FILL_W > 5) ? FILL_W : 5;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_READ = 3'b100
  } back_state_t;

  back_state_t       state, state_next;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic [FILL_W-1:0] fill_next;
  logic [11:0]       cur_type;
  logic [10:0]       amount;
  logic              rd_ok;
  logic              load_op;
  logic              load_out;
  logic              idx_ok;
  logic              last;

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_entry;
  logic              re;
  logic [IDX_W-1:0]  ra;
  logic              we;
  logic [IDX_W-1:0]  wa;
  entry_t            wd;

  assign idx_ok = CMP_W'(q_item.read_index) < CMP_W'(fill);
  assign last   = (FILL_W'(scan_idx) + FILL_W'(1)) >= fill;

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    fill_next     = fill;
    q_pop         = 1'b0;
    load_op       = 1'b0;
    load_out      = 1'b0;
    re            = 1'b0;
    ra            = '0;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          load_op = 1'b1;
          if (q_item.kind == OP_READ) begin
            re         = idx_ok;
            ra         = IDX_W'(q_item.read_index);
            state_next = B_READ;
          end else if (fill == '0) begin
            we        = 1'b1;
            wd        = '{type_code: q_item.type_code, count: 32'(q_item.amount)};
            fill_next = fill + FILL_W'(1);
          end else begin
            re            = 1'b1;
            scan_idx_next = '0;
            state_next    = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (rd_entry.type_code == cur_type) begin
          we         = 1'b1;
          wa         = scan_idx;
          wd         = '{type_code: cur_type, count: rd_entry.count + 32'(amount)};
          state_next = B_IDLE;
        end else if (last) begin
          if (fill < FILL_W'(TABLE_DEPTH)) begin
            we        = 1'b1;
            wa        = IDX_W'(fill);
            wd        = '{type_code: cur_type, count: 32'(amount)};
            fill_next = fill + FILL_W'(1);
          end
          state_next = B_IDLE;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
          re            = 1'b1;
          ra            = scan_idx + IDX_W'(1);
        end
      end
      B_READ: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_entry <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (load_op) begin
      cur_type <= q_item.type_code;
      amount   <= q_item.amount;
      rd_ok    <= idx_ok;
    end
    if (load_out) begin
      entry_valid <= rd_ok;
      entry_type  <= rd_ok ? rd_entry.type_code : 12'd0;
      entry_bytes <= rd_ok ? rd_entry.count : 32'd0;
      table_fill  <= 5'(fill);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      scan_idx  <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      fill     <= fill_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/rtcm3_frame_type_byte_counter_top.sv =====
// top level of the rtcm3 frame type byte counter
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   command, data_byte, read_index
//   out      output     out_valid / out_ready entry_valid, entry_type,
//                                             entry_bytes, table_fill
//
// a feed byte is taken while the queue has room; a read leaves the queue and returns via
// the table memory's read register and the result register; a frame end is credited by
// the table engine, one entry compared per cycle through the table memory's single read port
// the input stalls only while the four-entry queue is full; a waiting result holds the engine
// synchronous reset clears the parser, queue, fill count and result valid
`include "rtcm3_frame_type_byte_counter_top_macros.svh"

module rtcm3_frame_type_byte_counter_top
  import rtcm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  data_byte,
  input  logic [4:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        entry_valid,
  output logic [11:0] entry_type,
  output logic [31:0] entry_bytes,
  output logic [4:0]  table_fill
);

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

  logic              q_push;
  queue_item_t       q_push_item;
  logic              q_full;
  logic              q_valid;
  queue_item_t       q_item;
  logic              q_pop;
  logic [FILL_W-1:0] fill;

  rtcm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .data_byte  (data_byte),
    .read_index (read_index),
    .q_full     (q_full),
    .push       (q_push),
    .push_item  (q_push_item)
  );

  rtcm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .pop       (q_pop)
  );

  rtcm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .entry_valid (entry_valid),
    .entry_type  (entry_type),
    .entry_bytes (entry_bytes),
    .table_fill  (table_fill),
    .fill        (fill)
  );

  `RTCM_ASSERT_IMPLY(a_invalid_read_zero, clk, rst, out_valid && !entry_valid, (entry_type == 12'd0) && (entry_bytes == 32'd0), "invalid read carries entry data")
  `RTCM_ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, fill <= FILL_W'(TABLE_DEPTH), "fill count beyond table depth")
  `RTCM_ASSERT_NEXT(a_fill_monotonic, clk, rst, 1'b1, fill >= $past(fill), "fill count decreased")

endmodule
